FILE: rtl/sha256bc_pkg.sv
// shared types, constants and round functions of the sha-256 block compression engine
// no dependencies
package sha256bc_pkg;

	// queue entry as classified by the front part
	typedef struct packed {
		logic        restart;
		logic [31:0] word;
	} cmd_t;

	// head of the queue as seen by the back part
	typedef struct packed {
		logic        valid;
		cmd_t        cmd;
	} qhead_t;

	localparam int unsigned HASH_WORDS  = 8;
	localparam int unsigned BLOCK_WORDS = 16;

	localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
		input logic [31:0] g);
		choose = (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c);
		majority = (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

FILE: rtl/sha256_block_compress_top.sv
// top level of the sha-256 block compression engine
// depends on sha256bc_pkg, sha256bc_front, sha256bc_core
//
// usage: raise start with mode 0 to reload the chaining words with the standard initial
// values, or with mode 1 and msg_word to load the next 32-bit big-endian block word; a word
// is taken at each rising edge where start is high and busy is low. busy rises only when the
// input queue is full. after the sixteenth word the engine runs 64 rounds at one round per
// cycle, then a feed-forward add, then puts the eight chaining words on digest_word
// back to back, each marked by done, with word_index 0..7 and last on the
// eighth; the receiver must take them as they come. while it computes and emits a block, the
// back part pops no words, so the next block's words wait in the queue and busy can rise.
// restart words and ordinary block words are each popped only while the back part is idle.
// padding is the host's job; chaining carries across blocks until the next restart.
module sha256_block_compress_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [31:0] msg_word,
	output logic        done,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
	import sha256bc_pkg::*;

	qhead_t head;
	logic   pop;

	// front: takes and classifies words, buffers a few so the host sees few stalls
	sha256bc_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mode     (mode),
		.msg_word (msg_word),
		.busy     (busy),
		.pop      (pop),
		.head     (head)
	);

	// back: loads the block, runs the rounds and streams out the digest words
	sha256bc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.done        (done),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last        (last)
	);

endmodule

FILE: rtl/sha256bc_front.sv
// front part: accepts words, classifies restart versus message word, short queue
// depends on sha256bc_pkg
module sha256bc_front #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  mode,
	input  logic [31:0]           msg_word,
	output logic                  busy,
	input  logic                  pop,
	output sha256bc_pkg::qhead_t  head
);
	import sha256bc_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          do_pop;
	cmd_t          cmd_in;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign busy   = (count_q == CW'(QUEUE_DEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (count_q != '0);

	// mode 0 restarts the chaining, mode 1 carries a block word
	assign cmd_in.restart = !mode;
	assign cmd_in.word    = msg_word;

	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/sha256bc_core.sv
// back part: word buffer, 64-round compression loop and digest emission
// depends on sha256bc_pkg
module sha256bc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256bc_pkg::qhead_t  head,
	output logic                  pop,
	output logic                  done,
	output logic [31:0]           digest_word,
	output logic [2:0]            word_index,
	output logic                  last
);
	import sha256bc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  count_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic [31:0] chain_q [HASH_WORDS];
	logic [31:0] var_q [HASH_WORDS];
	logic [31:0] sched_q [BLOCK_WORDS];

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] sched_new;

	// sched_q[j] holds schedule word round+j
	always_comb begin
		t1 = var_q[7] + bsig1(var_q[4]) + choose(var_q[4], var_q[5], var_q[6])
			+ ROUND_K[round_q] + sched_q[0];
		t2 = bsig0(var_q[0]) + majority(var_q[0], var_q[1], var_q[2]);
		sched_new = ssig1(sched_q[14]) + sched_q[9] + ssig0(sched_q[1]) + sched_q[0];
	end

	assign pop         = (state_q == ST_IDLE) && head.valid;
	assign done        = (state_q == ST_EMIT);
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last        = done && (idx_q == 3'd7);

	// working variables and schedule window
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop && !head.cmd.restart) begin
					for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
						sched_q[j] <= sched_q[j+1];
					end
					sched_q[BLOCK_WORDS-1] <= head.cmd.word;
					if (count_q == 4'd15) begin
						for (int i = 0; i < HASH_WORDS; i++) begin
							var_q[i] <= chain_q[i];
						end
					end
				end
			end
			ST_ROUND: begin
				for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
					sched_q[j] <= sched_q[j+1];
				end
				sched_q[BLOCK_WORDS-1] <= sched_new;
				var_q[7] <= var_q[6];
				var_q[6] <= var_q[5];
				var_q[5] <= var_q[4];
				var_q[4] <= var_q[3] + t1;
				var_q[3] <= var_q[2];
				var_q[2] <= var_q[1];
				var_q[1] <= var_q[0];
				var_q[0] <= t1 + t2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			round_q <= '0;
			idx_q   <= '0;
			for (int i = 0; i < HASH_WORDS; i++) begin
				chain_q[i] <= INIT_HASH[i];
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.cmd.restart) begin
							count_q <= '0;
							for (int i = 0; i < HASH_WORDS; i++) begin
								chain_q[i] <= INIT_HASH[i];
							end
						end else begin
							count_q <= count_q + 4'd1;
							if (count_q == 4'd15) begin
								round_q <= '0;
								state_q <= ST_ROUND;
							end
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < HASH_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
					idx_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> done && (word_index == 3'd7))
		else $error("last without final digest word");
	a_emit_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done && (word_index == 3'($past(word_index) + 3'd1)))
		else $error("digest words not emitted back to back");
	a_emit_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(state_q == ST_FINAL))
		else $error("emission started without feed-forward add");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("queue popped during compression");
`endif

endmodule
